FILE: hdl/rstab_pkg.sv
// ---------------------------------------------------------------------------
// rstab_pkg
// shared types and constants of the ranked score table
// ---------------------------------------------------------------------------
`default_nettype none

package rstab_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int MAX_TOP_DEF  = 64;

    // request kinds
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_CHANGE = 2'd1;
    localparam logic [1:0] REQ_PLACE  = 2'd2;
    localparam logic [1:0] REQ_TOP    = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // one table entry
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] score;
    } entry_t;

endpackage

`default_nettype wire

FILE: hdl/ranked_score_table.sv
// ---------------------------------------------------------------------------
// ranked_score_table
// table of (id, score) entries kept sorted by descending score
// ---------------------------------------------------------------------------
//
//  channel  | direction | tdata (low bit up)                       | tuser    | tlast
//  s_       | in        | entry_id[31:0] score[63:32] top_count[70:64] | req_type | -
//  m_       | out       | place[7:0] out_id[39:8] out_score[71:40]  | status   | last
//
// an id search reads the occupied entries in turn, one read per cycle; each place an
//   entry moves on add or change is a read of the neighbour, then a compare and write
// a top query reads each item, then loads it into the output register once that is free;
//   all runs through the single read port of the entry memory
// reset clears the state, entry count, pending flag and output valid only; the memory needs no clearing pass
// one request at a time; a finished item waits in the output register while
//   the next request is taken
// ---------------------------------------------------------------------------
`default_nettype none

module ranked_score_table #(
    parameter int CAPACITY = rstab_pkg::CAPACITY_DEF,
    parameter int MAX_TOP  = rstab_pkg::MAX_TOP_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    // request items
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [71:0] s_tdata,   // entry_id, score, top_count, zero pad
    input  wire  [1:0]  s_tuser,   // req_type
    // result items
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata,   // place, out_id, out_score
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast    // last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NW = (CW > 7) ? CW : 7;

    // sequencer states
    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_SCAN   = 10'b0000000010,
        S_UP_RD  = 10'b0000000100,
        S_UP_CMP = 10'b0000001000,
        S_DN_RD  = 10'b0000010000,
        S_DN_CMP = 10'b0000100000,
        S_FIN    = 10'b0001000000,
        S_EMIT   = 10'b0010000000,
        S_TOP_RD = 10'b0100000000,
        S_TOP_OUT= 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // request held for the whole run
    logic [1:0]  req_reg, req_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] sc_reg, sc_next;
    logic [6:0]  n_reg, n_next;

    // table bookkeeping
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;       // search index, top index
    logic          pend_reg, pend_next;     // read data of cmp_addr is pending
    logic [AW-1:0] cmp_addr_reg, cmp_addr_next;
    logic [AW-1:0] pos_reg, pos_next;       // current place of the moving entry

    // result waiting for the output register
    logic [1:0]  r_status_reg, r_status_next;
    logic [7:0]  r_place_reg, r_place_next;
    logic [31:0] r_id_reg, r_id_next;
    logic [31:0] r_score_reg, r_score_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_status_reg, m_status_next;
    logic [7:0]  m_place_reg, m_place_next;
    logic [31:0] m_id_reg, m_id_next;
    logic [31:0] m_score_reg, m_score_next;
    logic        m_last_reg, m_last_next;

    // memory ports
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    rstab_pkg::entry_t wr_data, rd_data;

    logic        slot_free;
    logic        load_out;
    logic [6:0]  in_tc, n_cap;
    logic [CW-1:0] pos_p1;
    logic        top_last;

    rstab_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign slot_free = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);

    assign in_tc    = s_tdata[70:64];
    assign pos_p1   = CW'(pos_reg) + CW'(1);
    assign top_last = (NW'(idx_reg) + NW'(1)) == NW'(n_reg);

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        id_next       = id_reg;
        sc_next       = sc_reg;
        n_next        = n_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        cmp_addr_next = cmp_addr_reg;
        pos_next      = pos_reg;
        r_status_next = r_status_reg;
        r_place_next  = r_place_reg;
        r_id_next     = r_id_reg;
        r_score_next  = r_score_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        load_out      = 1'b0;
        m_status_next = m_status_reg;
        m_place_next  = m_place_reg;
        m_id_next     = m_id_reg;
        m_score_next  = m_score_reg;
        m_last_next   = m_last_reg;
        n_cap         = (in_tc > 7'(MAX_TOP)) ? 7'(MAX_TOP) : in_tc;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_next  = s_tuser;
                    id_next   = s_tdata[31:0];
                    sc_next   = s_tdata[63:32];
                    idx_next  = '0;
                    pend_next = 1'b0;
                    if (s_tuser == rstab_pkg::REQ_TOP) begin
                        if (NW'(cnt_reg) < NW'(n_cap)) begin
                            n_next = 7'(cnt_reg);
                        end else begin
                            n_next = n_cap;
                        end
                        if (n_cap == '0 || cnt_reg == '0) begin
                            r_status_next = rstab_pkg::ST_EMPTY;
                            r_place_next  = '0;
                            r_id_next     = '0;
                            r_score_next  = '0;
                            state_next    = S_EMIT;
                        end else begin
                            state_next = S_TOP_RD;
                        end
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // one read issued per cycle, compared in the cycle after
                if (pend_reg && rd_data.id == id_reg) begin
                    pend_next = 1'b0;
                    case (req_reg)
                        rstab_pkg::REQ_CHANGE: begin
                            pos_next   = cmp_addr_reg;
                            state_next = S_UP_RD;
                        end
                        rstab_pkg::REQ_PLACE: begin
                            r_status_next = rstab_pkg::ST_OK;
                            r_place_next  = 8'(cmp_addr_reg);
                            r_id_next     = rd_data.id;
                            r_score_next  = rd_data.score;
                            state_next    = S_EMIT;
                        end
                        default: begin
                            // duplicate id on add
                            r_status_next = rstab_pkg::ST_IGNORED;
                            r_place_next  = '0;
                            r_id_next     = '0;
                            r_score_next  = '0;
                            state_next    = S_EMIT;
                        end
                    endcase
                end else if (idx_reg < cnt_reg) begin
                    rd_en         = 1'b1;
                    rd_addr       = idx_reg[AW-1:0];
                    cmp_addr_next = idx_reg[AW-1:0];
                    idx_next      = idx_reg + CW'(1);
                    pend_next     = 1'b1;
                end else begin
                    pend_next    = 1'b0;
                    r_place_next = '0;
                    r_id_next    = '0;
                    r_score_next = '0;
                    if (req_reg == rstab_pkg::REQ_ADD) begin
                        if (cnt_reg == CW'(CAPACITY)) begin
                            r_status_next = rstab_pkg::ST_FULL;
                            state_next    = S_EMIT;
                        end else begin
                            pos_next   = cnt_reg[AW-1:0];
                            cnt_next   = cnt_reg + CW'(1);
                            state_next = S_UP_RD;
                        end
                    end else begin
                        r_status_next = rstab_pkg::ST_IGNORED;
                        state_next    = S_EMIT;
                    end
                end
            end

            S_UP_RD: begin
                if (pos_reg != '0) begin
                    rd_en      = 1'b1;
                    rd_addr    = pos_reg - AW'(1);
                    state_next = S_UP_CMP;
                end else begin
                    state_next = S_DN_RD;
                end
            end

            S_UP_CMP: begin
                // neighbor above has a lower score: it slides down one place
                if (sc_reg > rd_data.score) begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg;
                    wr_data    = rd_data;
                    pos_next   = pos_reg - AW'(1);
                    state_next = S_UP_RD;
                end else begin
                    state_next = S_DN_RD;
                end
            end

            S_DN_RD: begin
                if (pos_p1 < cnt_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = pos_reg + AW'(1);
                    state_next = S_DN_CMP;
                end else begin
                    state_next = S_FIN;
                end
            end

            S_DN_CMP: begin
                // neighbor below has a higher score: it slides up one place
                if (sc_reg < rd_data.score) begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg;
                    wr_data    = rd_data;
                    pos_next   = pos_reg + AW'(1);
                    state_next = S_DN_RD;
                end else begin
                    state_next = S_FIN;
                end
            end

            S_FIN: begin
                wr_en         = 1'b1;
                wr_addr       = pos_reg;
                wr_data.id    = id_reg;
                wr_data.score = sc_reg;
                r_status_next = rstab_pkg::ST_OK;
                r_place_next  = 8'(pos_reg);
                r_id_next     = id_reg;
                r_score_next  = sc_reg;
                state_next    = S_EMIT;
            end

            S_EMIT: begin
                if (slot_free) begin
                    load_out      = 1'b1;
                    m_status_next = r_status_reg;
                    m_place_next  = r_place_reg;
                    m_id_next     = r_id_reg;
                    m_score_next  = r_score_reg;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_TOP_RD: begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg[AW-1:0];
                state_next = S_TOP_OUT;
            end

            S_TOP_OUT: begin
                if (slot_free) begin
                    load_out      = 1'b1;
                    m_status_next = rstab_pkg::ST_OK;
                    m_place_next  = 8'(idx_reg);
                    m_id_next     = rd_data.id;
                    m_score_next  = rd_data.score;
                    m_last_next   = top_last;
                    idx_next      = idx_reg + CW'(1);
                    state_next    = top_last ? S_IDLE : S_TOP_RD;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        m_valid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        id_reg       <= id_next;
        sc_reg       <= sc_next;
        n_reg        <= n_next;
        idx_reg      <= idx_next;
        cmp_addr_reg <= cmp_addr_next;
        pos_reg      <= pos_next;
        r_status_reg <= r_status_next;
        r_place_reg  <= r_place_next;
        r_id_reg     <= r_id_next;
        r_score_reg  <= r_score_next;
        m_status_reg <= m_status_next;
        m_place_reg  <= m_place_next;
        m_id_reg     <= m_id_next;
        m_score_reg  <= m_score_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_score_reg, m_id_reg, m_place_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

FILE: hdl/rstab_mem.sv
// ---------------------------------------------------------------------------
// rstab_mem
// entry store: one write port, one read port with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module rstab_mem #(
    parameter int DEPTH = rstab_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                    aclk,
    input  wire                    wr_en,
    input  wire [AW-1:0]           wr_addr,
    input  rstab_pkg::entry_t      wr_data,
    input  wire                    rd_en,
    input  wire [AW-1:0]           rd_addr,
    output rstab_pkg::entry_t      rd_data
);

    rstab_pkg::entry_t mem [DEPTH];
    rstab_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: dv/ranked_score_table_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ranked_score_table_tb
// self-checking bench: random and directed add, change, place and top
// requests, results predicted by a software leaderboard and compared per item
// ---------------------------------------------------------------------------
`default_nettype none

module ranked_score_table_tb;

    localparam int CAP       = 256;
    localparam int TOP_MAX   = 64;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]  req;
        logic [31:0] id;
        logic [31:0] score;
        logic [6:0]  count;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  place;
        logic [31:0] id;
        logic [31:0] score;
        logic        last;
    } answer_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    ranked_score_table uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // leaderboard mirror: ids and scores by place
    logic [31:0] lb_ids [CAP];
    logic [31:0] lb_scores [CAP];
    int          lb_count;

    request_t    pending_reqs[$];
    answer_t     expected_answers[$];
    logic        calm;          // no random idling on either side
    logic        hold_sender;   // sender waits for all answers
    int          errors;
    int          n_reqs;
    int          n_answers;
    int          n_top_items;
    int          max_fill;
    int          idle_cycles;

    function automatic int find_entry(logic [31:0] id);
        for (int i = 0; i < lb_count; i++)
            if (lb_ids[i] == id) return i;
        return -1;
    endfunction

    function automatic void swap_places(int a, int b);
        logic [31:0] t;
        t = lb_ids[a]; lb_ids[a] = lb_ids[b]; lb_ids[b] = t;
        t = lb_scores[a]; lb_scores[a] = lb_scores[b]; lb_scores[b] = t;
    endfunction

    function automatic void push_answer(logic [1:0] st, int pl, logic [31:0] id,
                                        logic [31:0] sc, logic lst);
        answer_t a;
        a.status = st;
        a.place  = pl[7:0];
        a.id     = id;
        a.score  = sc;
        a.last   = lst;
        expected_answers = {expected_answers, a};
    endfunction

    // work out the answers of one accepted request and update the mirror
    function automatic void predict_leaderboard(request_t r);
        int pos;
        int n;
        pos = find_entry(r.id);
        case (r.req)
            rstab_pkg::REQ_ADD: begin
                if (pos >= 0) push_answer(rstab_pkg::ST_IGNORED, 0, 0, 0, 1'b1);
                else if (lb_count >= CAP) push_answer(rstab_pkg::ST_FULL, 0, 0, 0, 1'b1);
                else begin
                    pos = lb_count;
                    lb_ids[pos] = r.id;
                    lb_scores[pos] = r.score;
                    lb_count++;
                    while (pos > 0 && r.score > lb_scores[pos-1]) begin
                        swap_places(pos, pos - 1);
                        pos--;
                    end
                    push_answer(rstab_pkg::ST_OK, pos, r.id, r.score, 1'b1);
                end
            end
            rstab_pkg::REQ_CHANGE: begin
                if (pos < 0) push_answer(rstab_pkg::ST_IGNORED, 0, 0, 0, 1'b1);
                else begin
                    lb_scores[pos] = r.score;
                    while (pos > 0 && r.score > lb_scores[pos-1]) begin
                        swap_places(pos, pos - 1);
                        pos--;
                    end
                    while (pos + 1 < lb_count && r.score < lb_scores[pos+1]) begin
                        swap_places(pos, pos + 1);
                        pos++;
                    end
                    push_answer(rstab_pkg::ST_OK, pos, r.id, r.score, 1'b1);
                end
            end
            rstab_pkg::REQ_PLACE: begin
                if (pos < 0) push_answer(rstab_pkg::ST_IGNORED, 0, 0, 0, 1'b1);
                else push_answer(rstab_pkg::ST_OK, pos, lb_ids[pos], lb_scores[pos], 1'b1);
            end
            default: begin
                n = r.count;
                if (n > TOP_MAX) n = TOP_MAX;
                if (n > lb_count) n = lb_count;
                if (n == 0) push_answer(rstab_pkg::ST_EMPTY, 0, 0, 0, 1'b1);
                for (int i = 0; i < n; i++)
                    push_answer(rstab_pkg::ST_OK, i, lb_ids[i], lb_scores[i], i + 1 == n);
            end
        endcase
    endfunction

    // driver: next item from the queue, random gaps unless calm
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_leaderboard({s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[70:64]});
                n_reqs++;
                if (lb_count > max_fill) max_fill = lb_count;
                void'(pending_reqs.pop_front());
            end
            // offer the head of the queue, or idle
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 && !hold_sender
                    && (calm || $urandom_range(99) >= 26)) begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_reqs[0].req;
                    s_tdata  <= {1'b0, pending_reqs[0].count, pending_reqs[0].score,
                                 pending_reqs[0].id};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: ready stalls and per-field comparison
    always @(posedge aclk) begin
        answer_t exp_a;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 26);
            if (m_tvalid && m_tready) begin
                n_answers++;
                if (expected_answers.size() == 0) begin
                    $error("unexpected result item: status %0d", m_tuser);
                    errors++;
                end else begin
                    exp_a = expected_answers.pop_front();
                    if (exp_a.status == rstab_pkg::ST_OK && exp_a.last == 1'b0) n_top_items++;
                    if (m_tuser !== exp_a.status) begin
                        $error("status: expected %0d, got %0d", exp_a.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[7:0] !== exp_a.place) begin
                        $error("place: expected %0d, got %0d", exp_a.place, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[39:8] !== exp_a.id) begin
                        $error("out_id: expected %h, got %h", exp_a.id, m_tdata[39:8]);
                        errors++;
                    end
                    if (m_tdata[71:40] !== exp_a.score) begin
                        $error("out_score: expected %h, got %h", exp_a.score, m_tdata[71:40]);
                        errors++;
                    end
                    if (m_tlast !== exp_a.last) begin
                        $error("last: expected %0d, got %0d", exp_a.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ids from a small pool so hits and duplicates are common
    logic [31:0] id_pool [16];

    function automatic request_t make_req(logic [1:0] rq, logic [31:0] id,
                                          logic [31:0] sc, logic [6:0] cnt);
        request_t r;
        r.req = rq; r.id = id; r.score = sc; r.count = cnt;
        return r;
    endfunction

    function automatic void queue_req(request_t r);
        pending_reqs = {pending_reqs, r};
    endfunction

    function automatic logic [31:0] pick_score();
        case ($urandom_range(3))
            0: return $urandom_range(7);
            1: return 32'hFFFF_FFF8 | $urandom_range(7);
            default: return $urandom();
        endcase
    endfunction

    function automatic request_t random_req();
        logic [1:0]  rq;
        logic [31:0] id;
        rq = 2'($urandom_range(3));
        id = ($urandom_range(9) == 0) ? $urandom() : id_pool[$urandom_range(15)];
        return make_req(rq, id, pick_score(), 7'($urandom_range(127)));
    endfunction

    task automatic drain();
        wait (pending_reqs.size() == 0 && !s_tvalid);
        wait (expected_answers.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
        errors = 0; n_reqs = 0; n_answers = 0; n_top_items = 0; max_fill = 0;
        idle_cycles = 0; lb_count = 0; calm = 1'b0; hold_sender = 1'b0;
        for (int i = 0; i < 16; i++) id_pool[i] = $urandom();
        id_pool[0] = 32'h0; id_pool[1] = 32'hFFFF_FFFF;
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, extremes, duplicate, unknown ids, ties
        queue_req(make_req(rstab_pkg::REQ_TOP, 0, 0, 7'd127));
        queue_req(make_req(rstab_pkg::REQ_PLACE, 32'h0, 0, 0));
        queue_req(make_req(rstab_pkg::REQ_CHANGE, 32'hFFFF_FFFF, 5, 0));
        queue_req(make_req(rstab_pkg::REQ_ADD, 32'h0, 32'h0, 0));
        queue_req(make_req(rstab_pkg::REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
        queue_req(make_req(rstab_pkg::REQ_ADD, 32'h5555_AAAA, 32'h10, 0));
        queue_req(make_req(rstab_pkg::REQ_ADD, 32'hAAAA_5555, 32'h10, 0));
        queue_req(make_req(rstab_pkg::REQ_ADD, 32'h0, 32'h77, 0));
        queue_req(make_req(rstab_pkg::REQ_CHANGE, 32'h0, 32'hFFFF_FFFF, 0));
        queue_req(make_req(rstab_pkg::REQ_CHANGE, 32'hFFFF_FFFF, 32'h0, 0));
        queue_req(make_req(rstab_pkg::REQ_CHANGE, 32'h5555_AAAA, 32'h10, 0));
        queue_req(make_req(rstab_pkg::REQ_PLACE, 32'hAAAA_5555, 0, 0));
        queue_req(make_req(rstab_pkg::REQ_PLACE, 32'h1234_5678, 0, 0));
        queue_req(make_req(rstab_pkg::REQ_TOP, 0, 0, 7'd0));
        queue_req(make_req(rstab_pkg::REQ_TOP, 0, 0, 7'd2));
        queue_req(make_req(rstab_pkg::REQ_TOP, 0, 0, 7'd64));
        queue_req(make_req(rstab_pkg::REQ_TOP, 0, 0, 7'd65));
        drain();

        // pause until every answer is back, then random mix
        hold_sender = 1'b1;
        wait (expected_answers.size() == 0);
        hold_sender = 1'b0;
        for (int i = 0; i < 100; i++) queue_req(random_req());
        drain();

        // calm stretch with no idling
        calm = 1'b1;
        for (int i = 0; i < 60; i++) queue_req(random_req());
        drain();
        calm = 1'b0;

        // fill the table to capacity with fresh ids, hit full, then place and change random entries
        for (int i = 0; i < CAP + 4; i++)
            queue_req(make_req(rstab_pkg::REQ_ADD, 32'h8000_0000 + i, pick_score(), 0));
        queue_req(make_req(rstab_pkg::REQ_ADD, 32'h8000_0000, 0, 0));
        for (int i = 0; i < 20; i++) begin
            queue_req(make_req(rstab_pkg::REQ_PLACE, 32'h8000_0000 + $urandom_range(CAP-1),
                               0, 0));
            queue_req(make_req(rstab_pkg::REQ_CHANGE, 32'h8000_0000 + $urandom_range(CAP-1),
                               pick_score(), 0));
        end
        queue_req(make_req(rstab_pkg::REQ_TOP, 0, 0, 7'd127));
        drain();

        $display("%0d requests, %0d result items (%0d inside top runs), peak fill %0d",
                 n_reqs, n_answers, n_top_items, max_fill);
        $display("covered adds, changes, place and top queries, duplicates, full table");
        if (errors == 0 && expected_answers.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

`default_nettype wire
